[rtl/sida_pkg.sv]
package sida_pkg;

   localparam int VALUE_W       = 32;
   localparam int CHAR_W        = 7;
   localparam int DIGITS        = 10;
   localparam int DIGIT_W       = 4;
   localparam int BCD_W         = DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(CONV_STEPS);
   localparam int IDX_W         = $clog2(DIGITS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } item_type;

   typedef struct packed {
      logic             neg;
      logic [BCD_W-1:0] bcd;
   } bcd_item_type;

   typedef enum logic [2:0] {
      CV_IDLE = 3'b001,
      CV_RUN  = 3'b010,
      CV_HOLD = 3'b100
   } cv_state_type;

   typedef enum logic [2:0] {
      EM_IDLE  = 3'b001,
      EM_SIGN  = 3'b010,
      EM_DIGIT = 3'b100
   } em_state_type;

   // one shift-add-3 step: correct each digit, then shift in the next binary bit
   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

[rtl/sida_front.sv]
module sida_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [sida_pkg::VALUE_W-1:0] in_value,
   output logic                       out_valid,
   input  logic                       out_ready,
   output sida_pkg::item_type         out_item
);
   import sida_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_valid && in_ready) begin
         item_in.neg = in_value[VALUE_W-1];
         item_in.mag = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

[rtl/sida_queue.sv]
module sida_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  sida_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output sida_pkg::item_type out_item
);
   import sida_pkg::*;

   item_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[rtl/sida_conv.sv]
module sida_conv (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sida_pkg::item_type     in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sida_pkg::bcd_item_type out_item
);
   import sida_pkg::*;

   cv_state_type        state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic                neg_ff, neg_in;
   logic [BCD_W-1:0]    bcd_step;
   logic [VALUE_W-1:0]  bin_step;

   assign in_ready      = state_ff == CV_IDLE;
   assign out_valid     = state_ff == CV_HOLD;
   assign out_item.neg  = neg_ff;
   assign out_item.bcd  = bcd_ff;

   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         bcd_step = dabble(bcd_step, bin_step[VALUE_W-1]);
         bin_step = {bin_step[VALUE_W-2:0], 1'b0};
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         CV_IDLE: begin
            if (in_valid) begin
               neg_in   = in_item.neg;
               bin_in   = in_item.mag;
               bcd_in   = '0;
               step_in  = '0;
               state_in = CV_RUN;
            end
         end
         CV_RUN: begin
            bcd_in  = bcd_step;
            bin_in  = bin_step;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
               state_in = CV_HOLD;
            end
         end
         CV_HOLD: begin
            if (out_ready) begin
               state_in = CV_IDLE;
            end
         end
         default: state_in = CV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
   end

endmodule

[rtl/sida_emit.sv]
module sida_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  sida_pkg::bcd_item_type      in_item,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [sida_pkg::CHAR_W-1:0] out_char,
   output logic                        out_last
);
   import sida_pkg::*;

   em_state_type       state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   top_idx;
   logic [DIGIT_W-1:0] dig [DIGITS];
   logic               slot_free;

   assign in_ready  = state_ff == EM_IDLE;
   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      top_idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (in_item.bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
            top_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < DIGITS; i++) begin
         dig[i] = bcd_ff[i*DIGIT_W +: DIGIT_W];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      bcd_in   = bcd_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !out_ready;
      unique case (state_ff)
         EM_IDLE: begin
            if (in_valid) begin
               bcd_in   = in_item.bcd;
               idx_in   = top_idx;
               state_in = in_item.neg ? EM_SIGN : EM_DIGIT;
            end
         end
         EM_SIGN: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = EM_DIGIT;
            end
         end
         EM_DIGIT: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig[idx_ff]};
               last_in  = idx_ff == '0;
               if (idx_ff == '0) begin
                  state_in = EM_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: state_in = EM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      idx_ff  <= idx_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Formats one signed 32-bit integer per req beat as decimal ASCII text, one character per
// rsp beat: '-' for a negative value, then the digits most significant first with no leading
// zeros ("0" for zero), rsp_last high on the final character. The input register takes a
// value and passes sign and magnitude into a two-entry queue; the converter builds the BCD
// form four bits a cycle, and the character emitter sends one beat per cycle from its
// output register while rsp_ready is high. A number takes from one to eleven beats; the
// converter can start on the next number while the emitter still sends the last one's
// characters.
module signed_int_to_decimal_ascii (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [sida_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sida_pkg::CHAR_W-1:0]   rsp_ascii_char,
   output logic                          rsp_last
);
   import sida_pkg::*;

   logic         fr_valid, fr_ready;
   item_type     fr_item;
   logic         q_valid, q_ready;
   item_type     q_item;
   logic         cv_valid, cv_ready;
   bcd_item_type cv_item;

   sida_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_value  (req_value),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   sida_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   sida_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (cv_valid),
      .out_ready (cv_ready),
      .out_item  (cv_item)
   );

   sida_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cv_valid),
      .in_ready  (cv_ready),
      .in_item   (cv_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_char  (rsp_ascii_char),
      .out_last  (rsp_last)
   );

endmodule

[rtl/sida_checker.sv]
module sida_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [sida_pkg::VALUE_W-1:0] req_value,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sida_pkg::CHAR_W-1:0]   rsp_ascii_char,
   input logic                          rsp_last
);
   import sida_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_last))
      else $error("stalled rsp beat changed");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == CHAR_MINUS && !rsp_last)
                 || (rsp_ascii_char >= CHAR_ZERO && rsp_ascii_char <= CHAR_ZERO + 7'd9))
      else $error("illegal character or minus marked last");

   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_ascii_char == CHAR_MINUS
         |=> !rsp_valid || rsp_ascii_char != CHAR_MINUS)
      else $error("two minus signs in a row");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);
